[hdl/y2r_pkg.sv]
`timescale 1ns / 1ps

package y2r_pkg;

	// Field widths
	localparam int PIX_W   = 8;
	localparam int DIFF_W  = 9;   // chroma minus mid, -128..127
	localparam int COEF_W  = 19;  // unsigned Q2.16 held as signed
	localparam int PROD_W  = 28;  // Q.16 products and the G sum
	localparam int TERM_W  = 10;  // integer chroma term, -260..258
	localparam int SUM_W   = 11;  // luma plus term
	localparam int FRAC_W  = 16;

	// Q2.16 coefficients
	localparam logic signed [COEF_W-1:0] COEF_R_V = 19'sd74711;
	localparam logic signed [COEF_W-1:0] COEF_G_U = 19'sd25887;
	localparam logic signed [COEF_W-1:0] COEF_G_V = 19'sd38076;
	localparam logic signed [COEF_W-1:0] COEF_B_U = 19'sd133169;

	localparam logic [PIX_W-1:0] CHROMA_MID = 8'd128;
	localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;
	localparam logic [FRAC_W-1:0] FRAC_ONES = {FRAC_W{1'b1}};

	// Stage 1: lumas and centered chroma
	typedef struct packed {
		logic [PIX_W-1:0]         y0;
		logic [PIX_W-1:0]         y1;
		logic signed [DIFF_W-1:0] du;
		logic signed [DIFF_W-1:0] dv;
	} y2r_diff_t;

	// Stage 2: Q.16 products
	typedef struct packed {
		logic [PIX_W-1:0]         y0;
		logic [PIX_W-1:0]         y1;
		logic signed [PROD_W-1:0] p_rv;
		logic signed [PROD_W-1:0] p_gu;
		logic signed [PROD_W-1:0] p_gv;
		logic signed [PROD_W-1:0] p_bu;
	} y2r_prod_t;

	// Stage 3: integer chroma terms
	typedef struct packed {
		logic [PIX_W-1:0]         y0;
		logic [PIX_W-1:0]         y1;
		logic signed [TERM_W-1:0] tr;
		logic signed [TERM_W-1:0] tg;
		logic signed [TERM_W-1:0] tb;
	} y2r_term_t;

	// Stage 4: two RGB888 pixels
	typedef struct packed {
		logic [PIX_W-1:0] r0;
		logic [PIX_W-1:0] g0;
		logic [PIX_W-1:0] b0;
		logic [PIX_W-1:0] r1;
		logic [PIX_W-1:0] g1;
		logic [PIX_W-1:0] b1;
	} y2r_rgb_t;

	// Integer part of a Q.16 value, rounded toward zero
	function automatic logic signed [TERM_W-1:0] trunc_q16(
		input logic signed [PROD_W-1:0] x
	);
		logic signed [PROD_W-1:0] biased;
		logic signed [PROD_W-1:0] shifted;
		biased  = x + (x[PROD_W-1] ? PROD_W'(FRAC_ONES) : PROD_W'(0));
		shifted = biased >>> FRAC_W;
		return shifted[TERM_W-1:0];
	endfunction

	// Luma plus term, clamped to 0..255
	function automatic logic [PIX_W-1:0] clamp_pix(
		input logic [PIX_W-1:0]         y,
		input logic signed [TERM_W-1:0] t
	);
		logic signed [SUM_W-1:0] s;
		s = $signed({{(SUM_W-PIX_W){1'b0}}, y}) + SUM_W'(t);
		if (s <= 0) begin
			return '0;
		end else if (s >= $signed({{(SUM_W-PIX_W){1'b0}}, PIX_MAX})) begin
			return PIX_MAX;
		end else begin
			return s[PIX_W-1:0];
		end
	endfunction

endpackage

[hdl/y2r_yuy2_if.sv]
`timescale 1ns / 1ps

interface y2r_yuy2_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_luma;
	logic [7:0] first_chroma;
	logic [7:0] second_luma;
	logic [7:0] second_chroma;

	modport source (
		output valid, first_luma, first_chroma, second_luma, second_chroma,
		input  ready
	);
	modport sink (
		input  valid, first_luma, first_chroma, second_luma, second_chroma,
		output ready
	);
endinterface

[hdl/y2r_rgb_if.sv]
`timescale 1ns / 1ps

interface y2r_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_first;
	logic [7:0] green_first;
	logic [7:0] blue_first;
	logic [7:0] red_second;
	logic [7:0] green_second;
	logic [7:0] blue_second;

	modport source (
		output valid, red_first, green_first, blue_first,
		       red_second, green_second, blue_second,
		input  ready
	);
	modport sink (
		input  valid, red_first, green_first, blue_first,
		       red_second, green_second, blue_second,
		output ready
	);
endinterface

[hdl/y2r_chroma_mul.sv]
`timescale 1ns / 1ps

module y2r_chroma_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 swap,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           y0,
	input  logic [7:0]           c1,
	input  logic [7:0]           y1,
	input  logic [7:0]           c3,
	output logic                 out_valid,
	input  logic                 out_ready,
	output y2r_pkg::y2r_prod_t   out_data
);
	import y2r_pkg::*;

	logic      valid_s1;
	logic      valid_s2;
	logic      ready_s1;
	logic      ready_s2;
	y2r_diff_t diff_s1;
	y2r_prod_t prod_s2;
	y2r_diff_t diff_d;
	y2r_prod_t prod_d;

	// Stage advance: a stage loads when empty or when its beat moves on
	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Center chroma, pick U/V order
	always_comb begin
		logic signed [DIFF_W-1:0] d1;
		logic signed [DIFF_W-1:0] d3;
		d1 = $signed({1'b0, c1}) - $signed({1'b0, CHROMA_MID});
		d3 = $signed({1'b0, c3}) - $signed({1'b0, CHROMA_MID});
		diff_d.y0 = y0;
		diff_d.y1 = y1;
		diff_d.du = swap ? d3 : d1;
		diff_d.dv = swap ? d1 : d3;
	end

	// Four coefficient products
	always_comb begin
		logic signed [PROD_W-1:0] du_x;
		logic signed [PROD_W-1:0] dv_x;
		du_x = PROD_W'(diff_s1.du);
		dv_x = PROD_W'(diff_s1.dv);
		prod_d.y0   = diff_s1.y0;
		prod_d.y1   = diff_s1.y1;
		prod_d.p_rv = dv_x * PROD_W'(COEF_R_V);
		prod_d.p_gu = du_x * PROD_W'(COEF_G_U);
		prod_d.p_gv = dv_x * PROD_W'(COEF_G_V);
		prod_d.p_bu = du_x * PROD_W'(COEF_B_U);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) diff_s1 <= diff_d;
		if (ready_s2 && valid_s1) prod_s2 <= prod_d;
	end

	assign out_valid = valid_s2;
	assign out_data  = prod_s2;

	// A beat in stage 2 came out of stage 1
	a_s2_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("stage 2 filled without a stage 1 beat");

endmodule

[hdl/y2r_term.sv]
`timescale 1ns / 1ps

module y2r_term (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  y2r_pkg::y2r_prod_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output y2r_pkg::y2r_term_t out_data
);
	import y2r_pkg::*;

	logic      valid_s3;
	logic      ready_s3;
	y2r_term_t term_s3;
	y2r_term_t term_d;

	assign ready_s3 = !valid_s3 || out_ready;
	assign in_ready = ready_s3;

	// G sum and truncation toward zero
	always_comb begin
		logic signed [PROD_W-1:0] g_sum;
		g_sum = -in_data.p_gu - in_data.p_gv;
		term_d.y0 = in_data.y0;
		term_d.y1 = in_data.y1;
		term_d.tr = trunc_q16(in_data.p_rv);
		term_d.tg = trunc_q16(g_sum);
		term_d.tb = trunc_q16(in_data.p_bu);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) term_s3 <= term_d;
	end

	assign out_valid = valid_s3;
	assign out_data  = term_s3;

	// B term is the widest; it stays within +-260
	a_tb_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (term_s3.tb <= 10'sd260 && term_s3.tb >= -10'sd260))
		else $error("blue term out of range");

endmodule

[hdl/y2r_mix.sv]
`timescale 1ns / 1ps

module y2r_mix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  y2r_pkg::y2r_term_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output y2r_pkg::y2r_rgb_t  out_data
);
	import y2r_pkg::*;

	logic     valid_s4;
	logic     ready_s4;
	logic     load;
	y2r_rgb_t rgb_s4;
	y2r_rgb_t rgb_d;

	assign ready_s4 = !valid_s4 || out_ready;
	assign in_ready = ready_s4;
	assign load     = ready_s4 && in_valid;

	// Add terms to each luma, clamp
	always_comb begin
		rgb_d.r0 = clamp_pix(in_data.y0, in_data.tr);
		rgb_d.g0 = clamp_pix(in_data.y0, in_data.tg);
		rgb_d.b0 = clamp_pix(in_data.y0, in_data.tb);
		rgb_d.r1 = clamp_pix(in_data.y1, in_data.tr);
		rgb_d.g1 = clamp_pix(in_data.y1, in_data.tg);
		rgb_d.b1 = clamp_pix(in_data.y1, in_data.tb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s4) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) rgb_s4 <= rgb_d;
	end

	assign out_valid = valid_s4;
	assign out_data  = rgb_s4;

	// Non-negative term never darkens, non-positive never brightens
	a_blue_up: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !in_data.tb[TERM_W-1]) |=> (rgb_s4.b0 >= $past(in_data.y0)))
		else $error("blue dropped below luma on a positive term");

	a_red_down: assert property (@(posedge clk) disable iff (!arst_n)
		(load && (in_data.tr[TERM_W-1] || in_data.tr == '0))
		|=> (rgb_s4.r1 <= $past(in_data.y1)))
		else $error("red rose above luma on a negative term");

endmodule

[hdl/yuy2_to_rgb_converter_core.sv]
`timescale 1ns / 1ps

// Channel   Dir  Beat
// pix_in    in   one YUY2 macropixel: Y0, C1, Y1, C3
// pix_out   out  two RGB888 pixels sharing the chroma
// cfg       in   chroma_swap bit (cfg_wr_en, cfg_wr_data)
//
// One macropixel per clock while pix_out is not stalled; four register stages,
// so a beat reaches pix_out.valid once it has passed through all four.
// Stages: chroma select, coefficient multiply, G sum and truncate,
// luma add and clamp. Each stage loads when empty or when its beat moves on,
// so a stall on pix_out backs up stage by stage without losing a beat.
// Reset clears all valid bits and chroma_swap.
module yuy2_to_rgb_converter_core (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_wr_en,
	input  logic   cfg_wr_data,
	y2r_yuy2_if.sink  pix_in,
	y2r_rgb_if.source pix_out
);
	import y2r_pkg::*;

	logic      chroma_swap_q;
	logic      mul_valid;
	logic      mul_ready;
	y2r_prod_t mul_data;
	logic      term_valid;
	logic      term_ready;
	y2r_term_t term_data;
	y2r_rgb_t  rgb_data;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chroma_swap_q <= 1'b0;
		end else if (cfg_wr_en) begin
			chroma_swap_q <= cfg_wr_data;
		end
	end

	y2r_chroma_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.swap      (chroma_swap_q),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.y0        (pix_in.first_luma),
		.c1        (pix_in.first_chroma),
		.y1        (pix_in.second_luma),
		.c3        (pix_in.second_chroma),
		.out_valid (mul_valid),
		.out_ready (mul_ready),
		.out_data  (mul_data)
	);

	y2r_term u_term (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mul_valid),
		.in_ready  (mul_ready),
		.in_data   (mul_data),
		.out_valid (term_valid),
		.out_ready (term_ready),
		.out_data  (term_data)
	);

	y2r_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (term_valid),
		.in_ready  (term_ready),
		.in_data   (term_data),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.out_data  (rgb_data)
	);

	assign pix_out.red_first    = rgb_data.r0;
	assign pix_out.green_first  = rgb_data.g0;
	assign pix_out.blue_first   = rgb_data.b0;
	assign pix_out.red_second   = rgb_data.r1;
	assign pix_out.green_second = rgb_data.g1;
	assign pix_out.blue_second  = rgb_data.b1;

endmodule
